// ----- hdl/rrc_pkg.sv -----
// Shared constants, register indexes and width helpers for the rounded-rectangle coverage block.
package rrc_pkg;

	localparam int CFG_W = 11;
	localparam int PIX_W = 10;
	localparam int COV_W = 8;
	localparam int IDX_W = 2;

	localparam int MAX_DIM_DEF   = 1024;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_RADIUS = IDX_W'(2);

	// width of dimensions and half-pixel offsets before sign
	function automatic int base_w(input int max_dim);
		int dw;
		dw = $clog2(max_dim + 1);
		return (dw > CFG_W) ? dw : CFG_W;
	endfunction

	// root bits of the corner distance, one cell per bit
	function automatic int sqrt_stages(input int max_dim, input int frac_bits);
		int rw0;
		rw0 = 2 * (base_w(max_dim) + 1) + 1 + 2 * frac_bits;
		return (rw0 + 1) >> 1;
	endfunction

endpackage

// ----- hdl/rrc_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit and passes it on.
module rrc_sqrt_cell #(
	parameter int QW = 21,
	parameter int TW = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            prev_vld,
	input  logic [2*QW-1:0] prev_rad,
	input  logic [QW-1:0]   prev_root,
	input  logic [QW:0]     prev_rem,
	input  logic [TW-1:0]   prev_tag,
	output logic            next_vld,
	output logic [2*QW-1:0] next_rad,
	output logic [QW-1:0]   next_root,
	output logic [QW:0]     next_rem,
	output logic [TW-1:0]   next_tag
);

	localparam int RW = 2 * QW;

	logic [QW+2:0]   rem_sh;
	logic [QW+2:0]   trial;
	logic [QW+2:0]   diff;
	logic            ge;
	logic            vld_q;
	logic [RW-1:0]   rad_q;
	logic [QW-1:0]   root_q;
	logic [QW:0]     rem_q;
	logic [TW-1:0]   tag_q;

	always_comb begin
		rem_sh = {prev_rem, prev_rad[RW-1:RW-2]};
		trial  = {1'b0, prev_root, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {prev_rad[RW-3:0], 2'b00};
		root_q <= {prev_root[QW-2:0], ge};
		rem_q  <= ge ? diff[QW:0] : rem_sh[QW:0];
		tag_q  <= prev_tag;
	end

	assign next_vld  = vld_q;
	assign next_rad  = rad_q;
	assign next_root = root_q;
	assign next_rem  = rem_q;
	assign next_tag  = tag_q;

endmodule

// ----- hdl/round_rect_coverage_mask.sv -----
// Top level: rounded-rectangle anti-aliased coverage, fully pipelined.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------
//   pixel    | start / busy       | pixel_x, pixel_y
//   result   | done (strobe)      | coverage
//   config   | cfg_we             | cfg_index, cfg_wdata
//
// One pixel per clock; busy stays low. The done strobe rises once an accepted pixel
// has passed the stage 1 to 4 registers, the chain cells and the stage 5 and 6 registers,
// QW being the root bits of the corner distance (21 at the defaults), one chain cell per bit.
// Reset clears all valid flags and loads width 1, height 1, radius 0.
// The receiver cannot stall; every result appears for one cycle.
module round_rect_coverage_mask #(
	parameter int MAX_DIM   = rrc_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rrc_pkg::PIX_W-1:0] pixel_x,
	input  logic [rrc_pkg::PIX_W-1:0] pixel_y,
	output logic                      done,
	output logic [rrc_pkg::COV_W-1:0] coverage,
	input  logic                      cfg_we,
	input  logic [rrc_pkg::IDX_W-1:0] cfg_index,
	input  logic [rrc_pkg::CFG_W-1:0] cfg_wdata
);

	import rrc_pkg::*;

	localparam int BW  = base_w(MAX_DIM);
	localparam int SW  = BW + 3;
	localparam int AW  = BW + 1;
	localparam int SQW = 2 * AW + 1;
	localparam int QW  = sqrt_stages(MAX_DIM, FRAC_BITS);
	localparam int RW  = 2 * QW;
	localparam int GW  = BW + 2;
	localparam int TW  = GW + 1;
	localparam int NW  = ((QW > GW + FRAC_BITS) ? QW : GW + FRAC_BITS) + 2;
	localparam int TTW = FRAC_BITS + COV_W + 2;

	logic [CFG_W-1:0] cfg_w_q, cfg_h_q, cfg_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_W'(1);
			cfg_h_q <= CFG_W'(1);
			cfg_r_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  cfg_w_q <= cfg_wdata;
				REG_HEIGHT: cfg_h_q <= cfg_wdata;
				REG_RADIUS: cfg_r_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: effective geometry and absolute offsets from center
	logic [BW-1:0]        w_ext, h_ext, r_ext, w_eff, h_eff, min_wh, maxr, r_eff;
	logic signed [SW-1:0] ofx, ofy;
	logic [SW-1:0]        ofx_abs, ofy_abs;
	logic                 accept;

	always_comb begin
		accept  = start && !busy;
		w_ext   = BW'(cfg_w_q);
		h_ext   = BW'(cfg_h_q);
		r_ext   = BW'(cfg_r_q);
		w_eff   = (w_ext > BW'(MAX_DIM)) ? BW'(MAX_DIM) : w_ext;
		h_eff   = (h_ext > BW'(MAX_DIM)) ? BW'(MAX_DIM) : h_ext;
		min_wh  = (w_eff < h_eff) ? w_eff : h_eff;
		maxr    = min_wh >> 1;
		r_eff   = (r_ext > maxr) ? maxr : r_ext;
		ofx     = $signed(SW'({pixel_x, 1'b1})) - $signed(SW'(w_eff));
		ofy     = $signed(SW'({pixel_y, 1'b1})) - $signed(SW'(h_eff));
		ofx_abs = ofx[SW-1] ? SW'(-ofx) : SW'(ofx);
		ofy_abs = ofy[SW-1] ? SW'(-ofy) : SW'(ofy);
	end

	logic          vld_s1, zero_s1;
	logic [AW-1:0] dx_s1, dy_s1;
	logic [BW-1:0] ex_s1, ey_s1;
	logic [BW:0]   r2_s1;

	always_ff @(posedge clk) begin
		dx_s1   <= AW'(ofx_abs);
		dy_s1   <= AW'(ofy_abs);
		ex_s1   <= w_eff - {r_eff[BW-2:0], 1'b0};
		ey_s1   <= h_eff - {r_eff[BW-2:0], 1'b0};
		r2_s1   <= {r_eff, 1'b0};
		zero_s1 <= (w_eff == '0) || (h_eff == '0);
	end

	// stage 2: signed distance past the inner box per axis
	logic                 vld_s2, zero_s2;
	logic signed [SW-1:0] ax_s2, ay_s2;
	logic [BW:0]          r2_s2;

	always_ff @(posedge clk) begin
		ax_s2   <= $signed(SW'(dx_s1)) - $signed(SW'(ex_s1));
		ay_s2   <= $signed(SW'(dy_s1)) - $signed(SW'(ey_s1));
		r2_s2   <= r2_s1;
		zero_s2 <= zero_s1;
	end

	// stage 3: squares and the inside term folded with the radius
	logic [AW-1:0]        axc, ayc;
	logic signed [SW-1:0] in_term;
	logic [SW-1:0]        neg_in;
	logic                 vld_s3, zero_s3;
	logic [2*AW-1:0]      sqx_s3, sqy_s3;
	logic [GW-1:0]        g_s3;

	always_comb begin
		axc     = ax_s2[SW-1] ? '0 : AW'(ax_s2);
		ayc     = ay_s2[SW-1] ? '0 : AW'(ay_s2);
		in_term = (ax_s2 > ay_s2) ? ax_s2 : ay_s2;
		neg_in  = in_term[SW-1] ? SW'(-in_term) : '0;
	end

	always_ff @(posedge clk) begin
		sqx_s3  <= axc * axc;
		sqy_s3  <= ayc * ayc;
		g_s3    <= GW'(r2_s2) + GW'(neg_in);
		zero_s3 <= zero_s2;
	end

	// stage 4: radicand
	logic             vld_s4, zero_s4;
	logic [SQW-1:0]   sq_s4;
	logic [GW-1:0]    g_s4;

	always_ff @(posedge clk) begin
		sq_s4   <= SQW'(sqx_s3) + SQW'(sqy_s3);
		g_s4    <= g_s3;
		zero_s4 <= zero_s3;
	end

	// square root chain
	logic          vld_c  [QW+1];
	logic [RW-1:0] rad_c  [QW+1];
	logic [QW-1:0] root_c [QW+1];
	logic [QW:0]   rem_c  [QW+1];
	logic [TW-1:0] tag_c  [QW+1];

	assign vld_c[0]  = vld_s4;
	assign rad_c[0]  = RW'({sq_s4, {(2 * FRAC_BITS){1'b0}}});
	assign root_c[0] = '0;
	assign rem_c[0]  = '0;
	assign tag_c[0]  = {zero_s4, g_s4};

	for (genvar i = 0; i < QW; i++) begin : g_cell
		rrc_sqrt_cell #(
			.QW(QW),
			.TW(TW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_vld (vld_c[i]),
			.prev_rad (rad_c[i]),
			.prev_root(root_c[i]),
			.prev_rem (rem_c[i]),
			.prev_tag (tag_c[i]),
			.next_vld (vld_c[i+1]),
			.next_rad (rad_c[i+1]),
			.next_root(root_c[i+1]),
			.next_rem (rem_c[i+1]),
			.next_tag (tag_c[i+1])
		);
	end

	// stage 5: doubled coverage n = one - outside + g * one
	logic                 vld_s5, zero_s5;
	logic signed [NW-1:0] n_s5;

	always_ff @(posedge clk) begin
		n_s5    <= $signed(NW'(tag_c[QW][GW-1:0]) << FRAC_BITS)
			+ $signed(NW'(1) << FRAC_BITS) - $signed(NW'(root_c[QW]));
		zero_s5 <= tag_c[QW][GW];
	end

	// stage 6: clamp and scale to 0..255
	logic [FRAC_BITS:0] n_lo;
	logic [TTW-1:0]     t;
	logic [COV_W-1:0]   cov_next;
	logic               vld_s6;
	logic [COV_W-1:0]   cov_s6;

	always_comb begin
		n_lo = n_s5[FRAC_BITS:0];
		t    = (TTW'(n_lo) << COV_W) - TTW'(n_lo) + (TTW'(1) << FRAC_BITS);
		if (zero_s5 || n_s5 <= 0) begin
			cov_next = '0;
		end else if (n_s5 >= $signed(NW'(1) << (FRAC_BITS + 1))) begin
			cov_next = '1;
		end else begin
			cov_next = t[FRAC_BITS+COV_W:FRAC_BITS+1];
		end
	end

	always_ff @(posedge clk) begin
		cov_s6 <= cov_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_c[QW];
			vld_s6 <= vld_s5;
		end
	end

	assign done     = vld_s6;
	assign coverage = cov_s6;

endmodule

// ----- hdl/rrc_checker.sv -----
// Port-level checks for the coverage block, bound to the top level.
module rrc_checker #(
	parameter int MAX_DIM   = rrc_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [rrc_pkg::PIX_W-1:0] pixel_x,
	input logic [rrc_pkg::PIX_W-1:0] pixel_y,
	input logic                      done,
	input logic [rrc_pkg::COV_W-1:0] coverage,
	input logic                      cfg_we,
	input logic [rrc_pkg::IDX_W-1:0] cfg_index,
	input logic [rrc_pkg::CFG_W-1:0] cfg_wdata
);

	import rrc_pkg::*;

	localparam int LAT = sqrt_stages(MAX_DIM, FRAC_BITS) + 6;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_fwd_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT (done && !$isunknown(coverage)))
		else $error("transaction result missing at fixed latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching transaction");

	a_pix_known: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown({pixel_x, pixel_y}))
		else $error("unknown pixel on an accepted transaction");

	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown({cfg_index, cfg_wdata}))
		else $error("unknown register write");

endmodule

bind round_rect_coverage_mask rrc_checker #(
	.MAX_DIM  (MAX_DIM),
	.FRAC_BITS(FRAC_BITS)
) u_rrc_checker (.*);
